// ----- hdl/otm_pkg.sv -----
// Shared widths, reset values and the verdict word for the overcurrent trip monitor.
// No dependencies; every other file in hdl refers to it by scoped names.
package otm_pkg;

  localparam int unsigned SAMPLE_W           = 14;
  localparam int unsigned THRESH_W           = 14;
  localparam int unsigned WINDOW_LEN_DEFAULT = 8;
  localparam int unsigned S_TDATA_W          = 16;
  localparam int unsigned M_TDATA_W          = 8;
  localparam int unsigned COUNT_W            = 2;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 14'd4000;
  localparam logic [COUNT_W-1:0]  TRIP_STRIKES = 2'd3;

  typedef struct packed {
    logic newly_tripped;
    logic tripped;
  } verdict_t;

endpackage

// ----- hdl/otm_cell.sv -----
// One stage of the sample window: holds a sample and hands it on when the window advances.
// Depends on otm_pkg.
module otm_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [otm_pkg::SAMPLE_W-1:0]  din,
  output logic [otm_pkg::SAMPLE_W-1:0]  dout
);

  logic [otm_pkg::SAMPLE_W-1:0] held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (advance) begin
      held <= din;
    end
  end

  assign dout = held;

endmodule

// ----- hdl/otm_judge.sv -----
// Running sum, trip limits, over-count and trip latch of the overcurrent trip monitor.
// Depends on otm_pkg; fed by the row of otm_cell stages in the top level.
module otm_judge #(
  parameter int unsigned WindowLen = otm_pkg::WINDOW_LEN_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [otm_pkg::THRESH_W-1:0]  cfg_wr_data,
  input  logic                          accept,
  input  logic [otm_pkg::SAMPLE_W-1:0]  sample,
  input  logic [otm_pkg::SAMPLE_W-1:0]  oldest,
  output logic                          latched,
  output otm_pkg::verdict_t             verdict
);

  localparam int unsigned SUM_W   = $clog2(WindowLen * (2 ** otm_pkg::SAMPLE_W - 1) + 1);
  localparam int unsigned LIMIT_W = $clog2(WindowLen * (2 ** otm_pkg::THRESH_W) + 1);
  localparam int unsigned INST_W  = otm_pkg::THRESH_W + 1;
  localparam int unsigned TRI_W   = otm_pkg::THRESH_W + 2;
  localparam logic [LIMIT_W-1:0] LEN_L = LIMIT_W'(WindowLen);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET =
    LIMIT_W'((int'(otm_pkg::THRESH_RESET) + 1) * int'(WindowLen));
  localparam logic [INST_W-1:0] INST_RESET =
    INST_W'((int'(otm_pkg::THRESH_RESET) * 3) / 2);

  logic [SUM_W-1:0]            sum;
  logic [SUM_W-1:0]            sum_next;
  logic [LIMIT_W-1:0]          avg_limit;
  logic [LIMIT_W-1:0]          avg_limit_next;
  logic [INST_W-1:0]           inst_level;
  logic [TRI_W-1:0]            thresh_x3;
  logic [otm_pkg::COUNT_W-1:0] count;
  logic [otm_pkg::COUNT_W-1:0] count_next;
  logic [otm_pkg::COUNT_W:0]   count_inc;
  logic                        latch_next;
  logic                        fresh;
  logic                        over;
  logic                        update;

  assign update = accept && !latched;

  always_comb begin
    avg_limit_next = (LIMIT_W'(cfg_wr_data) + LIMIT_W'(1)) * LEN_L;
    thresh_x3      = TRI_W'(cfg_wr_data) + TRI_W'({cfg_wr_data, 1'b0});
  end

  always_comb begin
    sum_next   = sum + SUM_W'(sample) - SUM_W'(oldest);
    over       = (LIMIT_W'(sum_next) >= avg_limit) || (INST_W'(sample) > inst_level);
    count_inc  = {1'b0, count} + 1'b1;
    count_next = count;
    latch_next = latched;
    fresh      = 1'b0;
    if (over) begin
      if (count_inc >= {1'b0, otm_pkg::TRIP_STRIKES}) begin
        count_next = otm_pkg::TRIP_STRIKES;
        latch_next = 1'b1;
        fresh      = 1'b1;
      end else begin
        count_next = count_inc[otm_pkg::COUNT_W-1:0];
      end
    end else if (count != '0) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    verdict.tripped       = latched || latch_next;
    verdict.newly_tripped = !latched && fresh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_limit  <= LIMIT_RESET;
      inst_level <= INST_RESET;
    end else if (cfg_wr_en) begin
      avg_limit  <= avg_limit_next;
      inst_level <= thresh_x3[TRI_W-1:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum     <= '0;
      count   <= '0;
      latched <= 1'b0;
    end else if (update) begin
      sum     <= sum_next;
      count   <= count_next;
      latched <= latch_next;
    end
  end

endmodule

// ----- hdl/overcurrent_trip_monitor_unit.sv -----
// Top level of the overcurrent trip monitor: row of window cells, judge and output buffer.
// Depends on otm_pkg, otm_cell and otm_judge.
//
//   channel   direction  words                         handshake
//   s_*       in         sample_ma                     tvalid/tready
//   m_*       out        tripped, newly_tripped        tvalid/tready
//   cfg_*     in         trip_threshold_ma             cfg_wr_en, no back-pressure
//
// One word per cycle while s_tready is high; the result word is registered into the
// output buffer as the sample is taken, the running-sum update and compare in otm_judge
// being combinational. Synchronous reset clears the window, sum, count and latch.
// A two-word output buffer keeps s_tready high while one result waits on m_tready.
module overcurrent_trip_monitor_unit #(
  parameter int unsigned WINDOW_LEN = otm_pkg::WINDOW_LEN_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [otm_pkg::S_TDATA_W-1:0]  s_tdata,   // [13:0] sample_ma
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [otm_pkg::M_TDATA_W-1:0]  m_tdata,   // [0] tripped, [1] newly_tripped
  input  logic                           cfg_wr_en,
  input  logic [otm_pkg::THRESH_W-1:0]   cfg_wr_data
);

  logic [otm_pkg::SAMPLE_W-1:0] sample;
  logic [otm_pkg::SAMPLE_W-1:0] tap [WINDOW_LEN];
  logic                         accept;
  logic                         latched;
  logic                         advance;
  otm_pkg::verdict_t            verdict;
  otm_pkg::verdict_t            out_word;
  otm_pkg::verdict_t            skid_word;
  logic                         out_valid;
  logic                         skid_valid;

  assign sample  = s_tdata[otm_pkg::SAMPLE_W-1:0];
  assign accept  = s_tvalid && s_tready;
  assign advance = accept && !latched;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    if (i == 0) begin : g_head
      otm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .advance (advance),
        .din     (sample),
        .dout    (tap[i])
      );
    end else begin : g_body
      otm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .advance (advance),
        .din     (tap[i-1]),
        .dout    (tap[i])
      );
    end
  end

  otm_judge #(
    .WindowLen (WINDOW_LEN)
  ) u_judge (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .sample      (sample),
    .oldest      (tap[WINDOW_LEN-1]),
    .latched     (latched),
    .verdict     (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= accept;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_word  <= skid_word;
        skid_word <= verdict;
      end else begin
        out_word  <= verdict;
      end
    end else if (accept) begin
      skid_word <= verdict;
    end
  end

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(otm_pkg::M_TDATA_W - 2){1'b0}}, out_word.newly_tripped, out_word.tripped};

endmodule

// ----- dv/otm_trip_checker.sv -----
// Trip checker for the overcurrent trip monitor: predicts each result word and compares.
// Watches the sample, result and threshold channels; depends on otm_pkg only.
module otm_trip_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [otm_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [otm_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                          cfg_wr_en,
  input  logic [otm_pkg::THRESH_W-1:0]  cfg_wr_data,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = otm_pkg::WINDOW_LEN_DEFAULT;

  logic [otm_pkg::SAMPLE_W-1:0] ring [DEPTH];
  logic [$clog2(DEPTH)-1:0]     slot;
  logic [16:0]                  ring_sum;
  logic [otm_pkg::COUNT_W-1:0]  over_cnt;
  logic                         latched;
  logic [otm_pkg::THRESH_W-1:0] thresh;
  otm_pkg::verdict_t            verdicts_due [$];

  function automatic otm_pkg::verdict_t advance_window(
    input logic [otm_pkg::SAMPLE_W-1:0] sample);
    otm_pkg::verdict_t v;
    logic [16:0]       mean_level;
    logic [16:0]       burst_level;
    v = '0;
    if (!latched) begin
      ring_sum    = ring_sum - ring[slot] + sample;
      ring[slot]  = sample;
      slot        = (slot == DEPTH - 1) ? '0 : slot + 1'b1;
      mean_level  = 17'(ring_sum / DEPTH);
      burst_level = ({3'b000, thresh} * 17'd3) >> 1;
      if (mean_level > thresh || {3'b000, sample} > burst_level) begin
        over_cnt = over_cnt + 1'b1;
        if (over_cnt == otm_pkg::TRIP_STRIKES) begin
          latched         = 1'b1;
          v.newly_tripped = 1'b1;
        end
      end else if (over_cnt != '0) begin
        over_cnt = over_cnt - 1'b1;
      end
    end
    v.tripped = latched;
    return v;
  endfunction

  always @(posedge clk) begin
    otm_pkg::verdict_t seen;
    otm_pkg::verdict_t due;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) ring[i] = '0;
      slot     = '0;
      ring_sum = '0;
      over_cnt = '0;
      latched  = 1'b0;
      thresh   = otm_pkg::THRESH_RESET;
      verdicts_due.delete();
    end else begin
      if (cfg_wr_en) thresh = cfg_wr_data;
      if (s_tvalid && s_tready) begin
        verdicts_due.push_back(advance_window(s_tdata[otm_pkg::SAMPLE_W-1:0]));
      end
      if (m_tvalid && m_tready) begin
        seen = otm_pkg::verdict_t'(m_tdata[1:0]);
        if (verdicts_due.size() == 0) begin
          $error("result word with none due: tripped %0d, newly_tripped %0d",
                 seen.tripped, seen.newly_tripped);
          mismatches++;
        end else begin
          due = verdicts_due.pop_front();
          if (seen.tripped !== due.tripped) begin
            $error("tripped: expected %0d, got %0d", due.tripped, seen.tripped);
            mismatches++;
          end
          if (seen.newly_tripped !== due.newly_tripped) begin
            $error("newly_tripped: expected %0d, got %0d", due.newly_tripped,
                   seen.newly_tripped);
            mismatches++;
          end
          if (m_tdata[otm_pkg::M_TDATA_W-1:2] !== '0) begin
            $error("padding: expected 0, got %0h", m_tdata[otm_pkg::M_TDATA_W-1:2]);
            mismatches++;
          end
        end
      end
    end
    outstanding = verdicts_due.size();
  end

endmodule

// ----- dv/tb_overcurrent_trip_monitor_unit.sv -----
// Testbench top for overcurrent_trip_monitor_unit: clock, reset, sample and threshold
// stimulus, result back-pressure and the verdict. Depends on otm_pkg and otm_trip_checker.
module tb_overcurrent_trip_monitor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned                 RANDOM_PHASES    = 8;
  localparam int unsigned                 PHASE_WORDS      = 64;
  localparam int unsigned                 FLUSH_WORDS      = otm_pkg::WINDOW_LEN_DEFAULT;
  localparam logic [otm_pkg::THRESH_W-1:0] THRESH_MAX      = '1;
  localparam logic [otm_pkg::SAMPLE_W-1:0] SAMPLE_MAX      = '1;
  localparam int unsigned                 SPIKE_THRESH_MAX = 10921;

  logic                           clk         = 1'b0;
  logic                           rst         = 1'b1;
  logic                           s_tvalid    = 1'b0;
  logic                           s_tready;
  logic [otm_pkg::S_TDATA_W-1:0]  s_tdata     = '0;
  logic                           m_tvalid;
  logic                           m_tready    = 1'b0;
  logic [otm_pkg::M_TDATA_W-1:0]  m_tdata;
  logic                           cfg_wr_en   = 1'b0;
  logic [otm_pkg::THRESH_W-1:0]   cfg_wr_data = '0;
  int                             mismatches;
  int                             outstanding;

  int unsigned                    sent_words  = 0;
  bit                             s_eager     = 1'b0;
  bit                             m_eager     = 1'b0;
  logic [otm_pkg::THRESH_W-1:0]   thresh_now;
  logic [1:0]                     strikes;
  logic [7:0]                     spike_hist;

  always #1 clk = ~clk;

  overcurrent_trip_monitor_unit dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  otm_trip_checker trip_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  task automatic send_sample(input logic [otm_pkg::SAMPLE_W-1:0] sample);
    int unsigned gap;
    if (sent_words % 16 == 0) s_eager = ($urandom_range(3, 0) == 0);
    gap = s_eager ? 0 : $urandom_range(3, 0);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(otm_pkg::S_TDATA_W - otm_pkg::SAMPLE_W){1'b0}}, sample};
    do @(posedge clk); while (!s_tready);
    sent_words++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic write_threshold(input logic [otm_pkg::THRESH_W-1:0] value);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    thresh_now = value;
  endtask

  initial begin
    int unsigned burst_lvl;
    int unsigned spike_top;
    bit          spike;
    thresh_now = otm_pkg::THRESH_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // default threshold: instantaneous edge, truncated average edge, count to two and back
    send_sample(14'd0);    send_sample(14'd6000); send_sample(14'd6001);
    send_sample(14'd0);    send_sample(SAMPLE_MAX); send_sample(14'd0);
    send_sample(14'd3616); send_sample(14'd7);    send_sample(14'd8);
    send_sample(14'd0);    send_sample(14'd6001); send_sample(14'd6500);
    send_sample(14'd0);    send_sample(14'd0);
    repeat (FLUSH_WORDS) send_sample('0);

    // zero threshold: any nonzero sample counts
    write_threshold('0);
    send_sample(14'd0); send_sample(14'd1); send_sample(14'd0); send_sample(14'd0);

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase % 3 == 1) begin
        write_threshold(THRESH_MAX);
        repeat (PHASE_WORDS) send_sample(14'($urandom_range(SAMPLE_MAX, 0)));
      end else begin
        // spikes above the burst level, at most two per window, keep the mean below the
        // threshold, so the count rises only on spikes and never reaches the trip
        write_threshold(14'($urandom_range(SPIKE_THRESH_MAX, 1)));
        strikes    = '0;
        spike_hist = '0;
        burst_lvl  = (thresh_now * 3) / 2;
        spike_top  = (2 * thresh_now > SAMPLE_MAX) ? SAMPLE_MAX : 2 * thresh_now;
        repeat (PHASE_WORDS) begin
          spike = (strikes < 2) && ($countones(spike_hist[6:0]) <= 1) &&
                  ($urandom_range(2, 0) == 0);
          if (spike) send_sample(14'($urandom_range(spike_top, burst_lvl + 1)));
          else send_sample(14'($urandom_range(thresh_now / 2, 0)));
          spike_hist = {spike_hist[6:0], spike};
          if (spike) strikes++;
          else if (strikes != 0) strikes--;
        end
      end
      repeat (FLUSH_WORDS) send_sample('0);
    end

    // hold samples at the burst level until the mean trips, then keep sending
    write_threshold(14'($urandom_range(8000, 100)));
    burst_lvl = (thresh_now * 3) / 2;
    repeat (12) send_sample(14'(burst_lvl));
    repeat (16) send_sample(14'($urandom_range(SAMPLE_MAX, 0)));

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 16 == 0) m_eager = ($urandom_range(3, 0) == 0);
      stall = m_eager ? 0 : $urandom_range(3, 0);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
